// ----- design/ssc_pkg.sv -----
// ssc_pkg: shared types for the stack sort unit
// sequencer states and the result record passed to the output register
// no dependencies
package ssc_pkg;

	localparam int OUT_W = 16;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_CMP,
		ST_FLUSH,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             sortable;
		logic             last;
	} result_t;

endpackage

// ----- design/ssc_ram.sv -----
// ssc_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies
module ssc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/ssc_out_reg.sv -----
// ssc_out_reg: output holding register for the result stream
// depends on ssc_pkg for the result record
module ssc_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ssc_pkg::result_t d,
	output logic             free,
	output logic             valid,
	input  logic             ready,
	output ssc_pkg::result_t q
);

	import ssc_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= d;
		end
	end

endmodule

// ----- design/stack_sort_with_sortability_check_unit.sv -----
// stack_sort_with_sortability_check_unit: top level, load / sort / emit sequencer
// depends on ssc_pkg, ssc_ram, ssc_out_reg
//
// channel   dir  handshake            payload
// s_axis    in   tvalid / tready      tdata = sample_value, tlast = is_final
// m_axis    out  tvalid / tready      tdata = out_value, tuser = was_sortable,
//                                     tlast = end_of_run
//
// loading accepts each request on s_axis; the final request starts the sort
// sort: fetch the first element, then each compare step either pushes the next
// element onto the stack or pops the top entry into the sorted buffer
// emit: prime the buffer read in ST_EMIT_RD, then one result per cycle while
// m_axis_tready is high; the block takes new requests once the last result is
// in the output register. reset clears the sequencer, counters, flags and output valid only
module stack_sort_with_sortability_check_unit #(
	parameter int MAX_LEN     = 64,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [15:0]             s_axis_tdata,   // [15:0] sample_value
	input  logic                    s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [ssc_pkg::OUT_W-1:0] m_axis_tdata, // [15:0] out_value
	output logic                    m_axis_tuser,   // [0] was_sortable
	output logic                    m_axis_tlast
);

	import ssc_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int VW = VALUE_WIDTH;
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] TWO     = CW'(2);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] sp_q, sp_d;
	logic [CW-1:0] wr_q, wr_d;
	logic [VW-1:0] top_q, top_d;
	logic          top_src_q, top_src_d;
	logic [VW-1:0] prev_q, prev_d;
	logic          asc_q, asc_d;

	logic          in_we, in_re;
	logic [AW-1:0] in_waddr, in_raddr;
	logic [VW-1:0] in_rdata;
	logic          st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [VW-1:0] st_rdata;
	logic          ob_we, ob_re;
	logic [AW-1:0] ob_raddr;
	logic [VW-1:0] ob_rdata;

	logic          accept;
	logic [VW-1:0] top_val;
	logic [CW-1:0] idx_inc;
	logic          out_load, out_free;
	result_t       out_d, out_q;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign top_val = top_src_q ? st_rdata : top_q;
	assign idx_inc = idx_q + ONE;

	ssc_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (VW'(s_axis_tdata)),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	ssc_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_stack_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (in_rdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ssc_ram #(.WIDTH(VW), .DEPTH(MAX_LEN)) u_out_ram (
		.clk   (clk),
		.we    (ob_we),
		.waddr (wr_q[AW-1:0]),
		.wdata (top_val),
		.re    (ob_re),
		.raddr (ob_raddr),
		.rdata (ob_rdata)
	);

	ssc_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.d      (out_d),
		.free   (out_free),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.q      (out_q)
	);

	assign m_axis_tdata = out_q.value;
	assign m_axis_tuser = out_q.sortable;
	assign m_axis_tlast = out_q.last;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		sp_d      = sp_q;
		wr_d      = wr_q;
		top_d     = top_q;
		top_src_d = top_src_q;
		prev_d    = prev_q;
		asc_d     = asc_q;

		s_axis_tready = 1'b0;
		in_we    = 1'b0;
		in_waddr = cnt_q[AW-1:0];
		in_re    = 1'b0;
		in_raddr = idx_q[AW-1:0];
		st_we    = 1'b0;
		st_waddr = sp_q[AW-1:0];
		st_re    = 1'b0;
		st_raddr = AW'(sp_q - TWO);
		ob_we    = 1'b0;
		ob_re    = 1'b0;
		ob_raddr = idx_q[AW-1:0];
		out_load = 1'b0;
		out_d.value    = OUT_W'(asc_q ? ob_rdata : in_rdata);
		out_d.sortable = asc_q;
		out_d.last     = (idx_inc == cnt_q);

		case (state_q)
			ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (accept) begin
					if (cnt_q < LEN_MAX) begin
						in_we = 1'b1;
						cnt_d = cnt_q + ONE;
					end
					if (s_axis_tlast) begin
						idx_d     = '0;
						sp_d      = '0;
						wr_d      = '0;
						asc_d     = 1'b1;
						top_src_d = 1'b0;
						state_d   = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				in_re   = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP, ST_FLUSH: begin
				if (state_q == ST_FLUSH || (sp_q != '0 && in_rdata > top_val)) begin
					// pop the top entry into the sorted buffer
					ob_we = 1'b1;
					if (wr_q != '0 && prev_q > top_val) begin
						asc_d = 1'b0;
					end
					prev_d = top_val;
					wr_d   = wr_q + ONE;
					sp_d   = sp_q - ONE;
					if (sp_q > ONE) begin
						st_re     = 1'b1;
						top_src_d = 1'b1;
					end else if (state_q == ST_FLUSH) begin
						idx_d   = '0;
						state_d = ST_EMIT_RD;
					end
				end else begin
					// push and, if more elements remain, prefetch the next element
					st_we     = 1'b1;
					top_d     = in_rdata;
					top_src_d = 1'b0;
					sp_d      = sp_q + ONE;
					if (idx_inc < cnt_q) begin
						in_re    = 1'b1;
						in_raddr = idx_inc[AW-1:0];
						idx_d    = idx_inc;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_EMIT_RD: begin
				in_re   = !asc_q;
				ob_re   = asc_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (idx_inc == cnt_q) begin
						cnt_d   = '0;
						sp_d    = '0;
						state_d = ST_LOAD;
					end else begin
						idx_d    = idx_inc;
						in_re    = !asc_q;
						ob_re    = asc_q;
						in_raddr = idx_inc[AW-1:0];
						ob_raddr = idx_inc[AW-1:0];
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			idx_q     <= '0;
			sp_q      <= '0;
			wr_q      <= '0;
			top_src_q <= 1'b0;
			asc_q     <= 1'b1;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			idx_q     <= idx_d;
			sp_q      <= sp_d;
			wr_q      <= wr_d;
			top_src_q <= top_src_d;
			asc_q     <= asc_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q  <= top_d;
		prev_q <= prev_d;
	end

endmodule

// ----- sim/stack_sort_with_sortability_check_unit_tb.sv -----
// stack_sort_with_sortability_check_unit_tb: self-checking bench for the stack sort unit
// drives runs of samples into s_axis, predicts each emitted run and checks m_axis against it
// depends on ssc_pkg and stack_sort_with_sortability_check_unit
module stack_sort_with_sortability_check_unit_tb;

	import ssc_pkg::*;

	localparam int DEPTH      = 64;
	localparam int HOLD_LEN   = 400;
	localparam int STALL_MAX  = 5000;
	localparam int DRAIN_WAIT = 200;

	class sort_scoreboard;
		logic [15:0] loaded[$];
		result_t     expected[$];
		int          errors = 0;

		function int pending();
			return expected.size();
		endfunction

		// one accepted request; a final request closes the run and predicts its output
		function void note_request(logic [15:0] v, logic fin);
			logic [15:0] stk[$];
			logic [15:0] sorted[$];
			logic [15:0] x;
			logic        asc;
			result_t     r;
			if (loaded.size() < DEPTH)
				loaded.push_back(v);
			if (!fin)
				return;
			asc = 1'b1;
			for (int i = 0; i <= loaded.size(); i++) begin
				while (stk.size() > 0 && (i == loaded.size() || loaded[i] > stk[$])) begin
					x = stk.pop_back();
					if (sorted.size() > 0 && sorted[$] > x)
						asc = 1'b0;
					sorted.push_back(x);
				end
				if (i < loaded.size())
					stk.push_back(loaded[i]);
			end
			for (int k = 0; k < loaded.size(); k++) begin
				r.value    = asc ? sorted[k] : loaded[k];
				r.sortable = asc;
				r.last     = (k == loaded.size() - 1);
				expected.push_back(r);
			end
			loaded.delete();
		endfunction

		function void check_result(logic [15:0] v, logic srt, logic lst);
			result_t e;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result value %h sortable %b last %b",
					$time, v, srt, lst);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (e.value !== v) begin
				$display("%0t: out_value expected %h actual %h", $time, e.value, v);
				errors++;
			end
			if (e.sortable !== srt) begin
				$display("%0t: was_sortable expected %b actual %b", $time, e.sortable, srt);
				errors++;
			end
			if (e.last !== lst) begin
				$display("%0t: end_of_run expected %b actual %b", $time, e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tuser;
	logic              m_axis_tlast;

	sort_scoreboard sb;
	logic [15:0]    run_vals[$];
	int             snd_idle = 0;
	int             rcv_idle = 0;
	int             hold_reqs = 0;
	int             hold_seen = 0;
	int             hold_left = 0;
	int             samples_sent = 0;
	int             stall_cycles = 0;

	stack_sort_with_sortability_check_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_request(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// receiver: random back-pressure, or a long hold when asked for
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen     <= hold_reqs;
			hold_left     <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("FAIL stack_sort_with_sortability_check_unit");
			$finish;
		end
	end

	task automatic send_sample(input logic [15:0] v, input logic fin);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic send_run();
		foreach (run_vals[i])
			send_sample(run_vals[i], i == run_vals.size() - 1);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// stack-sortable sequence: a random push / pop walk fixes the order of ranks
	task automatic build_sortable(input int n);
		int          stk[$];
		int          ranks[DEPTH];
		logic [15:0] levels[DEPTH];
		int          pushed;
		int          rank;
		int          step_max;
		pushed   = 0;
		rank     = 0;
		step_max = 65000 / n;
		while (rank < n) begin
			if (pushed < n && (stk.size() == 0 || $urandom_range(0, 1))) begin
				stk.push_back(pushed);
				pushed++;
			end else begin
				ranks[stk.pop_back()] = rank;
				rank++;
			end
		end
		levels[0] = 16'($urandom_range(0, 65535 - n * step_max));
		for (int i = 1; i < n; i++)
			levels[i] = levels[i - 1] + 16'($urandom_range(1, step_max));
		run_vals.delete();
		for (int i = 0; i < n; i++)
			run_vals.push_back(levels[ranks[i]]);
	endtask

	task automatic build_random(input int n);
		run_vals.delete();
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0)
				run_vals.push_back(run_vals[$urandom_range(0, i - 1)]);
			else
				run_vals.push_back(16'($urandom_range(0, 65535)));
		end
	endtask

	task automatic random_runs(input int target);
		int stop_at;
		stop_at = samples_sent + target;
		while (samples_sent < stop_at) begin
			if ($urandom_range(0, 9) < 6)
				build_sortable($urandom_range(1, 8));
			else
				build_random($urandom_range(1, 8));
			send_run();
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 20;
		rcv_idle = 62;
		run_vals = '{16'h0000};
		send_run();
		run_vals = '{16'hffff};
		send_run();
		run_vals = '{16'haaaa, 16'h5555};
		send_run();
		run_vals = '{16'd2, 16'd3, 16'd1};
		send_run();
		run_vals = '{16'd3, 16'd1, 16'd2};
		send_run();
		run_vals = '{16'd5, 16'd5, 16'd3, 16'd5};
		send_run();
		run_vals = '{16'h0000, 16'hffff, 16'h0001, 16'hfffe};
		send_run();
		run_vals = '{16'hffff, 16'h0000, 16'hfffe, 16'h0001};
		send_run();
		wait_drained();
		random_runs(8);

		snd_idle = 62;
		rcv_idle = 20;
		// a full sortable buffer, then two requests beyond it, the final one among the dropped
		build_sortable(DEPTH);
		run_vals.push_back(16'h0001);
		run_vals.push_back(16'h0002);
		send_run();
		random_runs(8);
		wait_drained();

		snd_idle  = 0;
		rcv_idle  = 0;
		hold_reqs = hold_reqs + 1;
		random_runs(8);
		wait_drained();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS stack_sort_with_sortability_check_unit");
		else
			$display("FAIL stack_sort_with_sortability_check_unit");
		$finish;
	end

endmodule
